// ===== rtl/shwp_pkg.sv =====
// shared constants and types for the sync hunt word packer
package shwp_pkg;

    localparam int unsigned BYTE_W = 8;
    localparam int unsigned OUT_W = 32;
    localparam int unsigned SYNC_W = 64;

    // default sync word, first expected byte in bits 7:0
    localparam logic [SYNC_W-1:0] SYNC_RESET = 64'h2358_7843_6E59_735A;

    localparam int unsigned SYNC_LEN_DEF = 8;
    localparam int unsigned WORD_BYTES_DEF = 4;

    // packer result toward the output register
    typedef struct packed {
        logic             done;
        logic [OUT_W-1:0] word;
    } pack_res_t;

endpackage

// ===== rtl/shwp_hunter.sv =====
// sync word hunter: holds the sync register, match count and lock flag
module shwp_hunter #(
    parameter int unsigned SYNC_LEN = shwp_pkg::SYNC_LEN_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_we,
    input  logic [shwp_pkg::SYNC_W-1:0] cfg_wdata,
    input  logic                        step_en,
    input  logic [shwp_pkg::BYTE_W-1:0] byte_in,
    output logic                        locked
);

    localparam int unsigned MC_W = $clog2(SYNC_LEN);

    logic [shwp_pkg::SYNC_W-1:0] sync_word_reg, sync_word_next;
    logic [MC_W-1:0]             match_count_reg, match_count_next;
    logic                        locked_reg, locked_next;
    logic [shwp_pkg::BYTE_W-1:0] sync_bytes [SYNC_LEN];
    logic                        hit;

    for (genvar i = 0; i < SYNC_LEN; i++) begin : g_sync_bytes
        assign sync_bytes[i] = sync_word_reg[i*shwp_pkg::BYTE_W +: shwp_pkg::BYTE_W];
    end

    assign hit = (byte_in == sync_bytes[match_count_reg]);

    always_comb begin
        sync_word_next   = cfg_we ? cfg_wdata : sync_word_reg;
        match_count_next = match_count_reg;
        locked_next      = locked_reg;
        if (step_en && !locked_reg) begin
            if (!hit) begin
                // mismatch: restart, byte not retried against the first sync byte
                match_count_next = '0;
            end else if (match_count_reg == MC_W'(SYNC_LEN - 1)) begin
                locked_next      = 1'b1;
                match_count_next = '0;
            end else begin
                match_count_next = match_count_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sync_word_reg   <= shwp_pkg::SYNC_RESET;
            match_count_reg <= '0;
            locked_reg      <= 1'b0;
        end else begin
            sync_word_reg   <= sync_word_next;
            match_count_reg <= match_count_next;
            locked_reg      <= locked_next;
        end
    end

    assign locked = locked_reg;

`ifndef SYNTHESIS
    a_lock_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        locked_reg |=> locked_reg)
        else $error("lock dropped without reset");

    a_count_idle_locked: assert property (@(posedge aclk) disable iff (!aresetn)
        locked_reg |-> (match_count_reg == '0))
        else $error("match count moved after lock");
`endif

endmodule

// ===== rtl/shwp_packer.sv =====
// byte-to-word packer: byte lanes, fill count and word assembly
module shwp_packer #(
    parameter int unsigned WORD_BYTES = shwp_pkg::WORD_BYTES_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        pack_en,
    input  logic [shwp_pkg::BYTE_W-1:0] byte_in,
    output shwp_pkg::pack_res_t         res
);

    localparam int unsigned BC_W = $clog2(WORD_BYTES);
    localparam int unsigned FULL_W = WORD_BYTES * shwp_pkg::BYTE_W;

    logic [BC_W-1:0]             byte_count_reg, byte_count_next;
    logic [shwp_pkg::BYTE_W-1:0] held_reg [WORD_BYTES-1];
    logic [FULL_W-1:0]           full_word;
    logic                        last;

    assign last = (byte_count_reg == BC_W'(WORD_BYTES - 1));

    // held lanes; only read once all of them are written for the word
    for (genvar i = 0; i < WORD_BYTES - 1; i++) begin : g_lane
        always_ff @(posedge aclk) begin
            if (pack_en && (byte_count_reg == BC_W'(i))) begin
                held_reg[i] <= byte_in;
            end
        end
        assign full_word[i*shwp_pkg::BYTE_W +: shwp_pkg::BYTE_W] = held_reg[i];
    end
    assign full_word[FULL_W-1 -: shwp_pkg::BYTE_W] = byte_in;

    always_comb begin
        byte_count_next = byte_count_reg;
        if (pack_en) begin
            byte_count_next = last ? '0 : byte_count_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_count_reg <= '0;
        end else begin
            byte_count_reg <= byte_count_next;
        end
    end

    assign res.done = pack_en && last;

    if (FULL_W >= shwp_pkg::OUT_W) begin : g_trunc
        assign res.word = full_word[shwp_pkg::OUT_W-1:0];
    end else begin : g_ext
        assign res.word = {{(shwp_pkg::OUT_W - FULL_W){1'b0}}, full_word};
    end

`ifndef SYNTHESIS
    a_count_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        !pack_en |=> $stable(byte_count_reg))
        else $error("byte count moved without a packed byte");
`endif

endmodule

// ===== rtl/sync_hunt_word_packer.sv =====
// top level: input register, sync hunter, packer and result register
// a byte waits in the input register; a completed word then loads the result register
// one byte per cycle unless m_ready stalls; one word per WORD_BYTES bytes after lock
// rate is set by the single input register stage and the one-deep result register
// reset: synchronous active-low aresetn clears lock, counts and both valid flags,
// and loads the default sync word
module sync_hunt_word_packer #(
    parameter int unsigned SYNC_LEN   = shwp_pkg::SYNC_LEN_DEF,
    parameter int unsigned WORD_BYTES = shwp_pkg::WORD_BYTES_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    // sync word register write
    input  logic                        cfg_we,
    input  logic [shwp_pkg::SYNC_W-1:0] cfg_wdata,
    // byte request channel
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [shwp_pkg::BYTE_W-1:0] s_in_byte,
    // packed word channel
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [shwp_pkg::OUT_W-1:0]  m_packet_word
);

    // input stage
    logic                        in_valid_reg, in_valid_next;
    logic [shwp_pkg::BYTE_W-1:0] in_byte_reg;
    // result stage
    logic                        m_valid_reg, m_valid_next;
    logic [shwp_pkg::OUT_W-1:0]  m_packet_word_reg;

    logic                        fire;
    logic                        locked;
    shwp_pkg::pack_res_t         pack_res;

    // the held byte moves on whenever the result register is free or draining
    assign fire    = in_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || fire;

    shwp_hunter #(
        .SYNC_LEN (SYNC_LEN)
    ) u_hunter (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .step_en   (fire),
        .byte_in   (in_byte_reg),
        .locked    (locked)
    );

    // bytes go to the packer only once lock was already set, so the
    // byte that completes the sync word is dropped
    shwp_packer #(
        .WORD_BYTES (WORD_BYTES)
    ) u_packer (
        .aclk    (aclk),
        .aresetn (aresetn),
        .pack_en (fire && locked),
        .byte_in (in_byte_reg),
        .res     (pack_res)
    );

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end else if (fire) begin
            in_valid_next = 1'b0;
        end

        m_valid_next = m_valid_reg;
        if (pack_res.done) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_in_byte;
        end
        if (pack_res.done) begin
            m_packet_word_reg <= pack_res.word;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_packet_word = m_packet_word_reg;

`ifndef SYNTHESIS
    a_result_needs_lock: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> locked)
        else $error("result shown while still hunting");

    a_ready_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid_reg |-> s_ready)
        else $error("input stalled with empty result register");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_ready) |-> !pack_res.done)
        else $error("pending result overwritten");
`endif

endmodule
